### sv/clts_pkg.sv
// Shared types, register codes and channel helpers for the color LUT sampler.
// Used by every module of the block; depends on nothing.
`default_nettype none
package clts_pkg;

  localparam int CHANNEL_BITS = 16;
  localparam int FRAC_BITS    = 16;
  localparam int SIZE_BITS    = 13;
  localparam int STRENGTH_BITS = 17;
  localparam int DOMAIN_BITS  = 48;
  localparam int PIX_BITS     = 3 * CHANNEL_BITS;
  localparam int LATTICE_MAX_DEF = 33;
  localparam int CURVE_MAX_DEF   = 4096;
  localparam int PADDR_BITS   = 6;
  localparam int PDATA_BITS   = 64;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } clts_op_e;

  typedef enum logic [2:0] {
    REG_THREE_D  = 3'd0,
    REG_SIZE     = 3'd1,
    REG_STRENGTH = 3'd2,
    REG_DOM_LOW  = 3'd3,
    REG_DOM_HIGH = 3'd4
  } clts_reg_e;

  typedef struct packed {
    clts_op_e                op;
    logic [15:0]             entry_index;
    logic [CHANNEL_BITS-1:0] in_red;
    logic [CHANNEL_BITS-1:0] in_green;
    logic [CHANNEL_BITS-1:0] in_blue;
  } clts_cmd_t;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] out_red;
    logic [CHANNEL_BITS-1:0] out_green;
    logic [CHANNEL_BITS-1:0] out_blue;
  } clts_res_t;

  // Picks one color channel of a command, red being channel zero.
  function automatic logic [CHANNEL_BITS-1:0] cmd_chan(clts_cmd_t c, logic [1:0] ch);
    logic [CHANNEL_BITS-1:0] v;
    case (ch)
      2'd0:    v = c.in_red;
      2'd1:    v = c.in_green;
      default: v = c.in_blue;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

### sv/clts_divider.sv
// Pipelined restoring divider that normalizes one channel against its domain.
// Two quotient bits per stage; depends on clts_pkg.
`default_nettype none
module clts_divider import clts_pkg::*; (
  input  logic                    clk_i,
  input  logic [CHANNEL_BITS-1:0] v_i,
  input  logic [CHANNEL_BITS-1:0] lo_i,
  input  logic [CHANNEL_BITS-1:0] hi_i,
  output logic [CHANNEL_BITS:0]   norm_o
);
  localparam int Steps = 2;
  localparam int NStg  = CHANNEL_BITS / Steps;

  logic [CHANNEL_BITS-1:0] rem_q [NStg];
  logic [CHANNEL_BITS-1:0] quo_q [NStg];
  logic [CHANNEL_BITS-1:0] den_q [NStg];
  logic                    zero_q [NStg];
  logic                    one_q  [NStg];
  logic [CHANNEL_BITS-1:0] rem_d [NStg];
  logic [CHANNEL_BITS-1:0] quo_d [NStg];
  logic [CHANNEL_BITS-1:0] den_d [NStg];
  logic                    zero_d [NStg];
  logic                    one_d  [NStg];

  always_comb begin
    logic [CHANNEL_BITS-1:0] r;
    logic [CHANNEL_BITS-1:0] q;
    logic [CHANNEL_BITS-1:0] d;
    logic [CHANNEL_BITS:0]   t;
    for (int s = 0; s < NStg; s++) begin
      if (s == 0) begin
        r = v_i - lo_i;
        q = '0;
        d = hi_i - lo_i;
        zero_d[s] = (v_i <= lo_i);
        one_d[s]  = (v_i > lo_i) && (v_i >= hi_i);
      end else begin
        r = rem_q[s-1];
        q = quo_q[s-1];
        d = den_q[s-1];
        zero_d[s] = zero_q[s-1];
        one_d[s]  = one_q[s-1];
      end
      // The remainder stays below the divisor, so one compare per bit suffices.
      for (int j = 0; j < Steps; j++) begin
        t = {r, 1'b0};
        if (t >= {1'b0, d}) begin
          t = t - {1'b0, d};
          q = {q[CHANNEL_BITS-2:0], 1'b1};
        end else begin
          q = {q[CHANNEL_BITS-2:0], 1'b0};
        end
        r = t[CHANNEL_BITS-1:0];
      end
      rem_d[s] = r;
      quo_d[s] = q;
      den_d[s] = d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < NStg; s++) begin
      rem_q[s]  <= rem_d[s];
      quo_q[s]  <= quo_d[s];
      den_q[s]  <= den_d[s];
      zero_q[s] <= zero_d[s];
      one_q[s]  <= one_d[s];
    end
  end

  always_comb begin
    if (zero_q[NStg-1]) begin
      norm_o = '0;
    end else if (one_q[NStg-1]) begin
      norm_o = {1'b1, {CHANNEL_BITS{1'b0}}};
    end else begin
      norm_o = {1'b0, quo_q[NStg-1]};
    end
  end

endmodule
`default_nettype wire

### sv/clts_bank.sv
// One copy of the lattice store: one write port and one registered read port.
// Depends on clts_pkg for the entry width.
`default_nettype none
module clts_bank import clts_pkg::*; #(
  parameter int DEPTH = LATTICE_MAX_DEF * LATTICE_MAX_DEF * LATTICE_MAX_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AW-1:0]       waddr_i,
  input  logic [PIX_BITS-1:0] wdata_i,
  input  logic [AW-1:0]       raddr_i,
  output logic [PIX_BITS-1:0] rdata_o
);
  logic [PIX_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

### sv/color_lut_trilinear_sampler.sv
// Top level of the color LUT sampler: config registers, pipeline and banks.
// Depends on clts_pkg, clts_divider and clts_bank.
//
//   Channel   Ports                                   Handshake
//   command   start, busy, cmd_i                      taken when start & !busy
//   result    result_valid_o, res_o                   one-cycle strobe, no stall
//   config    psel penable pwrite paddr pwdata ...    APB, pready tied high
//
// One command enters every cycle; busy never rises. A sample's result strobe
// rises once the sample has passed the 8-stage channel divider, the index and weight
// stages, the store read, the 3-level corner adder tree and the blend. Loads write
// all eight store copies at the read stage, so order against samples holds. Reset
// clears the pipeline valid bits and the registers; the store holds no reset state.
// Nothing can stall.
`default_nettype none
module color_lut_trilinear_sampler import clts_pkg::*; #(
  parameter int LATTICE_MAX = LATTICE_MAX_DEF,
  parameter int CURVE_MAX   = CURVE_MAX_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  clts_cmd_t             cmd_i,
  output logic                  result_valid_o,
  output clts_res_t             res_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [PDATA_BITS-1:0] pwdata,
  output logic [PDATA_BITS-1:0] prdata,
  output logic                  pready
);
  localparam int CB    = CHANNEL_BITS;
  localparam int NW    = SIZE_BITS;
  localparam int DEPTH = LATTICE_MAX * LATTICE_MAX * LATTICE_MAX;
  localparam int AW    = $clog2(DEPTH);
  localparam int EW0   = $clog2(DEPTH + CURVE_MAX + 1);
  localparam int EW    = (EW0 > 17) ? EW0 : 17;
  localparam int NSTG  = 20;
  localparam int LAT   = 21;
  localparam logic [16:0] ONE = 17'h10000;

  // Configuration registers.
  logic                     three_d_q;
  logic [NW-1:0]            size_q;
  logic [STRENGTH_BITS-1:0] strength_q;
  logic [DOMAIN_BITS-1:0]   dom_lo_q;
  logic [DOMAIN_BITS-1:0]   dom_hi_q;
  logic                     cfg_we;
  clts_reg_e                cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = clts_reg_e'(paddr[5:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      three_d_q  <= 1'b1;
      size_q     <= NW'(33);
      strength_q <= STRENGTH_BITS'(65536);
      dom_lo_q   <= '0;
      dom_hi_q   <= '1;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_THREE_D:  three_d_q  <= pwdata[0];
        REG_SIZE:     size_q     <= pwdata[NW-1:0];
        REG_STRENGTH: strength_q <= pwdata[STRENGTH_BITS-1:0];
        REG_DOM_LOW:  dom_lo_q   <= pwdata[DOMAIN_BITS-1:0];
        REG_DOM_HIGH: dom_hi_q   <= pwdata[DOMAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_THREE_D:  prdata = PDATA_BITS'(three_d_q);
      REG_SIZE:     prdata = PDATA_BITS'(size_q);
      REG_STRENGTH: prdata = PDATA_BITS'(strength_q);
      REG_DOM_LOW:  prdata = PDATA_BITS'(dom_lo_q);
      REG_DOM_HIGH: prdata = PDATA_BITS'(dom_hi_q);
      default:      prdata = '0;
    endcase
  end

  // Effective lattice size, squared size and blend mix.
  logic [NW-1:0]      n;
  logic [NW-1:0]      nm1;
  logic [NW-1:0]      nm2;
  logic [EW-1:0]      nsq_q;
  logic [16:0]        mix;

  always_comb begin
    n = size_q;
    if (three_d_q) begin
      if (32'(size_q) > 32'(LATTICE_MAX)) n = NW'(LATTICE_MAX);
    end else begin
      if (32'(size_q) > 32'(CURVE_MAX)) n = NW'(CURVE_MAX);
    end
    if (n < NW'(2)) n = NW'(2);
  end
  assign nm1 = n - NW'(1);
  assign nm2 = n - NW'(2);
  assign mix = (strength_q > 17'(65536)) ? ONE : strength_q;

  always_ff @(posedge clk_i) begin
    nsq_q <= EW'(EW'(n) * EW'(n));
  end

  function automatic logic [16:0] wsel(logic d, logic [16:0] f);
    return d ? f : ONE - f;
  endfunction

  // Command pipeline: valid bits and payload travel together.
  logic [NSTG-1:0] valid_q;
  clts_cmd_t       cmd_q [NSTG];

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[NSTG-2:0], start && !busy};
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q[0] <= cmd_i;
    for (int k = 1; k < NSTG; k++) cmd_q[k] <= cmd_q[k-1];
  end

  // Stages 1 to 8: normalization.
  logic [CB:0] norm [3];
  for (genvar ch = 0; ch < 3; ch++) begin : g_div
    clts_divider u_div (
      .clk_i  (clk_i),
      .v_i    (cmd_chan(cmd_q[0], 2'(ch))),
      .lo_i   (dom_lo_q[ch*CB +: CB]),
      .hi_i   (dom_hi_q[ch*CB +: CB]),
      .norm_o (norm[ch])
    );
  end

  // Stages 9 to 12: cell index, fraction, base address and corner weights.
  logic [29:0]   scaled_q [3];
  logic [NW-1:0] idx10_q [3];
  logic [NW-1:0] idx11_q [3];
  logic [NW-1:0] idx12_q [3];
  logic [16:0]   frac10_q [3];
  logic [16:0]   frac11_q [3];
  logic [16:0]   frac12_q [3];
  logic [16:0]   frac13_q [3];
  logic [16:0]   frac14_q [3];
  logic [EW-1:0] t_q;
  logic [EW-1:0] base_q;
  logic [32:0]   pair_q [4];
  logic [48:0]   w12_q [8];
  logic [48:0]   w13_q [8];
  logic [48:0]   w14_q [8];

  always_ff @(posedge clk_i) begin
    logic [13:0] ip;
    logic [NW-1:0] ix;
    logic [29:0] rest;
    for (int ch = 0; ch < 3; ch++) begin
      scaled_q[ch] <= 30'(norm[ch]) * 30'(nm1);
      ip = scaled_q[ch][29:16];
      ix = (ip > 14'(nm2)) ? nm2 : ip[NW-1:0];
      idx10_q[ch]  <= ix;
      rest = scaled_q[ch] - {1'b0, ix, 16'b0};
      frac10_q[ch] <= rest[16:0];
      idx11_q[ch]  <= idx10_q[ch];
      idx12_q[ch]  <= idx11_q[ch];
      frac11_q[ch] <= frac10_q[ch];
      frac12_q[ch] <= frac11_q[ch];
      frac13_q[ch] <= frac12_q[ch];
      frac14_q[ch] <= frac13_q[ch];
    end
    t_q <= EW'(idx10_q[2]) * EW'(n) + EW'(idx10_q[1]);
    for (int p = 0; p < 4; p++) begin
      pair_q[p] <= 33'(wsel(p[0], frac10_q[0])) * 33'(wsel(p[1], frac10_q[1]));
    end
    base_q <= t_q * EW'(n) + EW'(idx11_q[0]);
    for (int c = 0; c < 8; c++) begin
      w12_q[c] <= 49'(pair_q[c % 4]) * 49'(wsel(c[2], frac11_q[2]));
      w13_q[c] <= w12_q[c];
      w14_q[c] <= w13_q[c];
    end
  end

  // Stage 13: eight read addresses; loads write at this stage too.
  logic [EW-1:0] addr_q [8];
  logic          oor_q [8];

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 8; c++) begin
      if (three_d_q) begin
        addr_q[c] <= base_q + EW'(c[0]) + (c[1] ? EW'(n) : '0) + (c[2] ? nsq_q : '0);
      end else if (c < 6) begin
        addr_q[c] <= EW'(idx12_q[c / 2]) + EW'(c[0]);
      end else begin
        addr_q[c] <= '0;
      end
      oor_q[c] <= (addr_q[c] >= EW'(DEPTH));
    end
  end

  logic [EW-1:0]       load_addr;
  logic                load_we;
  logic [PIX_BITS-1:0] load_data;
  logic [PIX_BITS-1:0] rd [8];

  assign load_addr = EW'(cmd_q[13].entry_index);
  assign load_we   = valid_q[13] && (cmd_q[13].op == OP_LOAD) && (load_addr < EW'(DEPTH));
  assign load_data = {cmd_q[13].in_blue, cmd_q[13].in_green, cmd_q[13].in_red};

  for (genvar c = 0; c < 8; c++) begin : g_bank
    clts_bank #(.DEPTH(DEPTH), .AW(AW)) u_bank (
      .clk_i   (clk_i),
      .we_i    (load_we),
      .waddr_i (load_addr[AW-1:0]),
      .wdata_i (load_data),
      .raddr_i (addr_q[c][AW-1:0]),
      .rdata_o (rd[c])
    );
  end

  // Stages 15 to 18: weighted products, adder tree and rounding.
  logic [63:0] prod_q [8][3];
  logic [32:0] pa_q [3];
  logic [32:0] pb_q [3];
  logic [63:0] s4_q [3][4];
  logic [63:0] s2_q [3][2];
  logic [CB-1:0] l1_q [3];
  logic [CB-1:0] l1b_q [3];
  logic [CB-1:0] look_q [3];

  always_ff @(posedge clk_i) begin
    logic [CB-1:0] v;
    logic [33:0] s1d;
    logic [63:0] s3d;
    for (int ch = 0; ch < 3; ch++) begin
      for (int c = 0; c < 8; c++) begin
        v = oor_q[c] ? '0 : rd[c][ch*CB +: CB];
        prod_q[c][ch] <= 64'(v) * 64'(w14_q[c]);
      end
      v = oor_q[2*ch] ? '0 : rd[2*ch][ch*CB +: CB];
      pa_q[ch] <= 33'(v) * 33'(ONE - frac14_q[ch]);
      v = oor_q[2*ch+1] ? '0 : rd[2*ch+1][ch*CB +: CB];
      pb_q[ch] <= 33'(v) * 33'(frac14_q[ch]);
      for (int j = 0; j < 4; j++) s4_q[ch][j] <= prod_q[2*j][ch] + prod_q[2*j+1][ch];
      s1d = 34'(pa_q[ch]) + 34'(pb_q[ch]) + 34'(32768);
      l1_q[ch] <= s1d[31:16];
      for (int j = 0; j < 2; j++) s2_q[ch][j] <= s4_q[ch][2*j] + s4_q[ch][2*j+1];
      l1b_q[ch] <= l1_q[ch];
      s3d = s2_q[ch][0] + s2_q[ch][1] + 64'h0000_8000_0000_0000;
      look_q[ch] <= three_d_q ? s3d[63:48] : l1b_q[ch];
    end
  end

  // Stages 19 and 20: blend with the input pixel.
  logic [32:0] bp_q [3];
  logic [32:0] bl_q [3];
  logic        res_valid_q;
  clts_res_t   res_q;

  always_ff @(posedge clk_i) begin
    logic [33:0] sb [3];
    for (int ch = 0; ch < 3; ch++) begin
      bp_q[ch] <= 33'(cmd_chan(cmd_q[18], 2'(ch))) * 33'(ONE - mix);
      bl_q[ch] <= 33'(look_q[ch]) * 33'(mix);
      sb[ch] = 34'(bp_q[ch]) + 34'(bl_q[ch]) + 34'(32768);
    end
    res_q <= '{out_red: sb[0][31:16], out_green: sb[1][31:16], out_blue: sb[2][31:16]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= valid_q[19] && (cmd_q[19].op == OP_SAMPLE);
    end
  end

  assign result_valid_o = res_valid_q;
  assign res_o          = res_q;

  // Sum of the eight corner weights, for checking.
  logic [51:0] wsum;
  always_comb begin
    wsum = '0;
    for (int c = 0; c < 8; c++) wsum = wsum + 52'(w12_q[c]);
  end

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy && cmd_i.op == OP_SAMPLE, LAT))
    else $error("result strobe without a sample taken at the pipeline depth");

  a_frac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[10] && cmd_q[10].op == OP_SAMPLE && frac10_q[0][16]) |->
      (frac10_q[0][15:0] == '0))
    else $error("red fraction above one");

  a_wsum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[12] && cmd_q[12].op == OP_SAMPLE && three_d_q) |->
      (wsum == (52'd1 << 48)))
    else $error("corner weights do not sum to one");

  a_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[13] && cmd_q[13].op == OP_SAMPLE && three_d_q) |->
      (addr_q[0] < EW'(DEPTH) && addr_q[7] < EW'(DEPTH)))
    else $error("cube corner address beyond the store");

endmodule
`default_nettype wire

### verif/color_lut_trilinear_sampler_tb.sv
// Self-checking color LUT sampler testbench: fills the low lattice entries, then
// walks directed and random load/sample commands across several register settings.
// Depends on clts_pkg and the color_lut_trilinear_sampler RTL.
`default_nettype none
module color_lut_trilinear_sampler_tb;
  import clts_pkg::*;

  localparam int STORE_DEPTH = LATTICE_MAX_DEF * LATTICE_MAX_DEF * LATTICE_MAX_DEF;
  localparam int FILL_DEPTH = 512;
  localparam int DRAIN_CYCLES = 30;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  clts_cmd_t             cmd_i;
  logic                  result_valid_o;
  clts_res_t             res_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_BITS-1:0] paddr;
  logic [PDATA_BITS-1:0] pwdata;
  logic [PDATA_BITS-1:0] prdata;
  logic                  pready;

  color_lut_trilinear_sampler u_dut (
    .clk_i, .rst_ni, .start, .busy, .cmd_i, .result_valid_o, .res_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // Shadow of the block's registers and lattice store.
  logic                     mode_3d;
  logic [SIZE_BITS-1:0]     size_reg;
  logic [STRENGTH_BITS-1:0] strength_reg;
  logic [15:0]              dom_lo [3];
  logic [15:0]              dom_hi [3];
  logic [PIX_BITS-1:0]      lattice_mem [STORE_DEPTH];

  // A typed expectation travels with the command it belongs to.
  logic      typed_next;
  clts_res_t typed_value;

  clts_res_t expected_colors[$];
  int        mismatches;
  int        samples_seen;
  int        loads_sent;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("color_lut_trilinear_sampler_tb: errors");
    $finish;
  end

  function automatic logic [63:0] lut_read(int ch, logic [63:0] e);
    if (e >= STORE_DEPTH) return 64'd0;
    return 64'(lattice_mem[e][16*ch +: 16]);
  endfunction

  function automatic clts_res_t predict_color(clts_cmd_t c);
    logic [63:0] px [3];
    logic [63:0] idx [3];
    logic [63:0] frac [3];
    logic [63:0] look [3];
    logic [63:0] n, norm, scaled, i, w, e, a, b, r, mix;
    logic [79:0] acc;
    clts_res_t   res;
    px[0] = 64'(c.in_red);
    px[1] = 64'(c.in_green);
    px[2] = 64'(c.in_blue);
    n = 64'(size_reg);
    if (mode_3d) begin
      if (n > LATTICE_MAX_DEF) n = LATTICE_MAX_DEF;
    end else begin
      if (n > CURVE_MAX_DEF) n = CURVE_MAX_DEF;
    end
    if (n < 2) n = 2;
    for (int ch = 0; ch < 3; ch++) begin
      if (px[ch] <= 64'(dom_lo[ch])) norm = 0;
      else if (px[ch] >= 64'(dom_hi[ch])) norm = 65536;
      else norm = ((px[ch] - 64'(dom_lo[ch])) << 16) / (64'(dom_hi[ch]) - 64'(dom_lo[ch]));
      scaled = norm * (n - 1);
      i = scaled >> 16;
      if (i > n - 2) i = n - 2;
      idx[ch] = i;
      frac[ch] = scaled - (i << 16);
    end
    for (int ch = 0; ch < 3; ch++) begin
      if (mode_3d) begin
        acc = 80'd0;
        for (int k = 0; k < 8; k++) begin
          w = (k[0] ? frac[0] : 65536 - frac[0]) * (k[1] ? frac[1] : 65536 - frac[1]);
          w = w * (k[2] ? frac[2] : 65536 - frac[2]);
          e = ((idx[2] + k[2]) * n + (idx[1] + k[1])) * n + (idx[0] + k[0]);
          acc += 80'(lut_read(ch, e)) * 80'(w);
        end
        r = 64'((acc + (80'd1 << 47)) >> 48);
      end else begin
        a = lut_read(ch, idx[ch]);
        b = lut_read(ch, idx[ch] + 1);
        r = (a * (65536 - frac[ch]) + b * frac[ch] + 32768) >> 16;
      end
      look[ch] = (r > 65535) ? 65535 : r;
    end
    mix = (strength_reg > 65536) ? 65536 : 64'(strength_reg);
    for (int ch = 0; ch < 3; ch++) begin
      r = px[ch];
      if (mix != 0) r = (px[ch] * (65536 - mix) + look[ch] * mix + 32768) >> 16;
      if (r > 65535) r = 65535;
      look[ch] = r;
    end
    res.out_red   = look[0][15:0];
    res.out_green = look[1][15:0];
    res.out_blue  = look[2][15:0];
    return res;
  endfunction

  // Accepts transactions on the command side and checks results in order.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (expected_colors.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", res_o);
      end else begin
        clts_res_t want;
        want = expected_colors.pop_front();
        if (want.out_red !== res_o.out_red || want.out_green !== res_o.out_green ||
            want.out_blue !== res_o.out_blue) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected r=%h g=%h b=%h, got r=%h g=%h b=%h",
                     want.out_red, want.out_green, want.out_blue,
                     res_o.out_red, res_o.out_green, res_o.out_blue);
        end
      end
    end
    if (rst_ni && start && !busy) begin
      if (cmd_i.op == OP_SAMPLE) begin
        if (typed_next) expected_colors.push_back(typed_value);
        else expected_colors.push_back(predict_color(cmd_i));
        samples_seen++;
      end else if (cmd_i.entry_index < STORE_DEPTH) begin
        lattice_mem[cmd_i.entry_index] = {cmd_i.in_blue, cmd_i.in_green, cmd_i.in_red};
      end
    end
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) return 0;
    if (roll < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Caller stands just after a rising edge; returns after the accepting edge and any idle gap.
  task automatic send_cmd(clts_cmd_t c, int gap);
    logic took;
    start <= 1'b1;
    cmd_i <= c;
    do begin
      @(negedge clk_i);
      took = !busy;
      @(posedge clk_i);
    end while (!took);
    if (c.op == OP_LOAD) loads_sent++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    int guard;
    guard = 0;
    start <= 1'b0;
    while (expected_colors.size() != 0 && guard < 10000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(clts_reg_e r, logic [63:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_BITS'({r, 3'b000});
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(negedge clk_i); while (!pready);
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    case (r)
      REG_THREE_D:  mode_3d = v[0];
      REG_SIZE:     size_reg = v[SIZE_BITS-1:0];
      REG_STRENGTH: strength_reg = v[STRENGTH_BITS-1:0];
      REG_DOM_LOW:  for (int ch = 0; ch < 3; ch++) dom_lo[ch] = v[16*ch +: 16];
      default:      for (int ch = 0; ch < 3; ch++) dom_hi[ch] = v[16*ch +: 16];
    endcase
  endtask

  task automatic apply_setting(logic m, logic [63:0] sz, logic [63:0] st,
                               logic [63:0] lo, logic [63:0] hi);
    wait_idle();
    write_reg(REG_THREE_D, 64'(m));
    write_reg(REG_SIZE, sz);
    write_reg(REG_STRENGTH, st);
    write_reg(REG_DOM_LOW, lo);
    write_reg(REG_DOM_HIGH, hi);
  endtask

  function automatic logic [15:0] pick_channel();
    case ($urandom_range(5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic run_random(int count);
    clts_cmd_t c;
    for (int k = 0; k < count; k++) begin
      c.op          = ($urandom_range(9) < 8) ? OP_SAMPLE : OP_LOAD;
      c.entry_index = ($urandom_range(3) == 0) ? 16'($urandom)
                                               : 16'($urandom_range(STORE_DEPTH - 1));
      c.in_red      = pick_channel();
      c.in_green    = pick_channel();
      c.in_blue     = pick_channel();
      send_cmd(c, ($urandom_range(7) == 0) ? 0 : pick_gap());
    end
  endtask

  typedef struct {
    clts_op_e    op;
    logic [15:0] index;
    logic [15:0] r, g, b;
    bit          typed;
    logic [15:0] er, eg, eb;
  } stim_row_t;

  stim_row_t directed_rows [] = '{
    '{OP_LOAD,   16'd0,     16'h1234, 16'h5678, 16'h9ABC, 1'b0, 16'h0, 16'h0, 16'h0},
    '{OP_LOAD,   16'd511,   16'hFFFF, 16'h0001, 16'h8000, 1'b0, 16'h0, 16'h0, 16'h0},
    '{OP_LOAD,   16'd35936, 16'h4321, 16'h8765, 16'hCBA9, 1'b0, 16'h0, 16'h0, 16'h0},
    '{OP_LOAD,   16'd35937, 16'hDEAD, 16'hDEAD, 16'hDEAD, 1'b0, 16'h0, 16'h0, 16'h0},
    '{OP_LOAD,   16'hFFFF,  16'hBEEF, 16'hBEEF, 16'hBEEF, 1'b0, 16'h0, 16'h0, 16'h0},
    '{OP_SAMPLE, 16'hFFFF,  16'h0000, 16'h0000, 16'h0000, 1'b1, 16'h1234, 16'h5678, 16'h9ABC},
    '{OP_SAMPLE, 16'h0000,  16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF, 16'h0001, 16'h8000},
    '{OP_SAMPLE, 16'h0000,  16'h8000, 16'h8000, 16'h8000, 1'b0, 16'h0, 16'h0, 16'h0},
    '{OP_SAMPLE, 16'h5555,  16'h0001, 16'hFFFE, 16'h7FFF, 1'b0, 16'h0, 16'h0, 16'h0},
    '{OP_SAMPLE, 16'hAAAA,  16'hFFFF, 16'h0000, 16'h8001, 1'b0, 16'h0, 16'h0, 16'h0},
    '{OP_SAMPLE, 16'h0000,  16'h07C1, 16'hF83E, 16'h4210, 1'b0, 16'h0, 16'h0, 16'h0}
  };

  initial begin
    clts_cmd_t c;
    rst_ni = 1'b0;
    start = 1'b0;
    cmd_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    typed_next = 1'b0;
    typed_value = '0;
    mismatches = 0;
    samples_seen = 0;
    loads_sent = 0;
    mode_3d = 1'b1;
    size_reg = 13'd33;
    strength_reg = 17'd65536;
    for (int ch = 0; ch < 3; ch++) begin
      dom_lo[ch] = 16'h0000;
      dom_hi[ch] = 16'hFFFF;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The low 512 entries are written before any sample, and every setting below keeps
    // its reads inside them: cubes of at most 8 points, curves of at most 512.
    for (int e = 0; e < FILL_DEPTH; e++) begin
      c.op = OP_LOAD;
      c.entry_index = 16'(e);
      c.in_red = 16'($urandom);
      c.in_green = 16'($urandom);
      c.in_blue = 16'($urandom);
      send_cmd(c, 0);
    end

    // Directed rows run on an 8-point cube; corner pixels land exactly on entries.
    apply_setting(1'b1, 64'd8, 64'd65536, 64'h0, 64'hFFFF_FFFF_FFFF);
    foreach (directed_rows[k]) begin
      c.op = directed_rows[k].op;
      c.entry_index = directed_rows[k].index;
      c.in_red = directed_rows[k].r;
      c.in_green = directed_rows[k].g;
      c.in_blue = directed_rows[k].b;
      typed_next <= directed_rows[k].typed;
      typed_value <= '{out_red: directed_rows[k].er, out_green: directed_rows[k].eg,
                       out_blue: directed_rows[k].eb};
      send_cmd(c, pick_gap());
    end
    typed_next <= 1'b0;

    run_random(80);
    apply_setting(1'b1, 64'd2, 64'd0, 64'h0, 64'hFFFF_FFFF_FFFF);
    run_random(70);
    apply_setting(1'b1, 64'd5, 64'd131071, 64'h1000_0800_0400, 64'hF000_E000_C000);
    run_random(70);
    apply_setting(1'b1, 64'd7, 64'd32768, 64'h8000_0000_FFFF, 64'h7FFF_FFFF_0001);
    run_random(70);
    apply_setting(1'b0, 64'd512, 64'd65536, 64'h0, 64'hFFFF_FFFF_FFFF);
    run_random(80);
    apply_setting(1'b0, 64'd0, 64'd70000, 64'h0100_0200_0300, 64'hFE00_FD00_FC00);
    run_random(70);
    apply_setting(1'b0, 64'd300, 64'd1, 64'h0, 64'hFFFF_FFFF_FFFF);
    run_random(70);
    apply_setting(1'b1, 64'd1, 64'd65535, 64'($urandom) << 16, 64'hFFFF_FFFF_FFFF);
    run_random(70);

    wait_idle();
    if (expected_colors.size() != 0) begin
      mismatches++;
      $display("%0d expected results never arrived", expected_colors.size());
    end
    $display("Filled the low lattice entries, sent %0d loads and checked %0d samples",
             loads_sent, samples_seen);
    $display("over cube and curve modes, size floors, strength extremes and empty domains.");
    if (mismatches == 0) begin
      $display("color_lut_trilinear_sampler_tb: clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("color_lut_trilinear_sampler_tb: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
